// ----- hdl/ddrc_pkg.sv -----
// Shared types, command codes and duty helpers for the differential drive ramp controller.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package ddrc_pkg;

    // Command codes carried in the input tuser
    typedef enum logic [3:0] {
        KIND_TICK      = 4'd0,
        KIND_FWD       = 4'd1,
        KIND_BACK      = 4'd2,
        KIND_STOP      = 4'd3,
        KIND_ESTOP     = 4'd4,
        KIND_TURN_L    = 4'd5,
        KIND_TURN_R    = 4'd6,
        KIND_CURVE_L   = 4'd7,
        KIND_CURVE_R   = 4'd8,
        KIND_SET_SPEED = 4'd9,
        KIND_SET_SMOOTH = 4'd10
    } t_kind;

    // Run direction codes; code 3 never arises and reads as stopped
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DEFAULT_SPEED = 2'd0;
    localparam logic [1:0] REG_RAMP_STEP     = 2'd1;
    localparam logic [1:0] REG_TRIM_OFFSET   = 2'd2;

    localparam logic [7:0]        DEFAULT_SPEED_RST = 8'd200;
    localparam logic [7:0]        RAMP_STEP_RST     = 8'd10;
    localparam logic signed [6:0] TRIM_MAX          = 7'sd50;
    localparam logic signed [6:0] TRIM_MIN          = -7'sd50;

    // Duty magnitude limit before masking to the 8-bit field
    localparam logic [15:0] DUTY_MAX = 16'd255;

    typedef struct packed {
        logic [7:0]        default_speed;
        logic [7:0]        ramp_step;
        logic signed [6:0] trim_offset;
    } t_cfg;

    typedef struct packed {
        logic [7:0] right_reverse;
        logic [7:0] right_forward;
        logic [7:0] left_reverse;
        logic [7:0] left_forward;
    } t_duty;

    // Limit a magnitude to DUTY_MAX and mask to the field width
    function automatic logic [7:0] duty_limit(input logic [7:0] mag);
        logic [15:0] lim;
        lim = ({8'd0, mag} > DUTY_MAX) ? DUTY_MAX : {8'd0, mag};
        return lim[7:0];
    endfunction

    // Floor of x / 3 for 8-bit x via reciprocal multiply (171 / 512)
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [16:0] prod;
        prod = {9'd0, x} * 17'd171;
        return prod[16:9];
    endfunction

endpackage

// ----- hdl/differential_drive_ramp_controller.sv -----
// Top level: input register, configuration registers, drive core and result buffer.
// Depends on ddrc_pkg, ddrc_core and ddrc_out_buf.
`timescale 1ns / 1ps

// Two-motor differential drive controller. Each input word is a command (tuser) with
// an optional speed (tdata); ticks ramp both motor levels toward the target and emit
// four PWM duties, turn, curve and emergency stop commands emit duties at once, and the
// remaining commands only update state. The block takes one word per cycle: a word is
// registered on entry and processed, once the buffer has room, by single-pass
// combinational logic, whose duties land in a two-entry output buffer, so input keeps
// flowing while one result waits. Input stalls only once the buffer holds two untaken
// results and a word is already registered.
module differential_drive_ramp_controller
    import ddrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] speed_value
    input  logic [3:0]  i_s_tuser,   // [3:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] left_forward_duty, [15:8] left_reverse_duty,
                                     // [23:16] right_forward_duty, [31:24] right_reverse_duty
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_kind      r_in_kind;
    logic [7:0] r_in_speed;

    logic       fire, has_result, buf_full, buf_valid, pop;
    t_duty      core_result, buf_data;
    logic signed [6:0] trim_wr;

    assign fire       = r_in_valid && !buf_full;
    assign o_s_tready = !r_in_valid || fire;
    assign pop        = buf_valid && i_m_tready;
    assign o_m_tvalid = buf_valid;
    assign o_m_tdata  = buf_data;

    always_comb begin
        trim_wr = $signed(i_cfg_wdata[6:0]);
        if (trim_wr > TRIM_MAX) begin
            trim_wr = TRIM_MAX;
        end else if (trim_wr < TRIM_MIN) begin
            trim_wr = TRIM_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_speed <= DEFAULT_SPEED_RST;
            r_cfg.ramp_step     <= RAMP_STEP_RST;
            r_cfg.trim_offset   <= 7'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEFAULT_SPEED: r_cfg.default_speed <= i_cfg_wdata;
                REG_RAMP_STEP:     r_cfg.ramp_step     <= i_cfg_wdata;
                REG_TRIM_OFFSET:   r_cfg.trim_offset   <= trim_wr;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the registered word until the core takes it
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_kind  <= t_kind'(i_s_tuser);
            r_in_speed <= i_s_tdata;
        end
    end

    ddrc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_in_kind),
        .i_speed_value(r_in_speed),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    ddrc_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fire && has_result),
        .i_data (core_result),
        .i_pop  (pop),
        .o_valid(buf_valid),
        .o_full (buf_full),
        .o_data (buf_data)
    );

    // A motor never gets forward and reverse duty together
    a_duty_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[7:0] != 8'd0 && o_m_tdata[15:8] != 8'd0) &&
                       !(o_m_tdata[23:16] != 8'd0 && o_m_tdata[31:24] != 8'd0))
        else $error("forward and reverse duty both active");

    // The core never processes a word while the buffer is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_full |-> !fire)
        else $error("result pushed into full buffer");

    // A registered word that is not processed stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid && $stable(r_in_kind) && $stable(r_in_speed))
        else $error("pending input word lost");

endmodule

// ----- hdl/ddrc_core.sv -----
// Drive state (direction, target, left and right levels) and the per-word update logic.
// Depends on ddrc_pkg.
`timescale 1ns / 1ps

module ddrc_core
    import ddrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_kind      i_kind,
    input  logic [7:0] i_speed_value,
    input  t_cfg       i_cfg,
    output logic       o_has_result,
    output t_duty      o_result
);

    logic [1:0] r_dir,   n_dir;
    logic [7:0] r_tgt,   n_tgt;
    logic [7:0] r_left,  n_left;
    logic [7:0] r_right, n_right;

    logic [7:0] ramp_left, ramp_right;
    logic [7:0] trim_left, trim_right;
    logic [5:0] trim_mag;
    logic [7:0] half_speed, third_speed, ds;

    // Move cur toward tgt by at most step
    function automatic logic [7:0] ramp(input logic [7:0] cur, input logic [7:0] tgt,
                                        input logic [7:0] step);
        logic [8:0] up;
        logic [7:0] res;
        up  = {1'b0, cur} + {1'b0, step};
        res = cur;
        if (cur < tgt) begin
            res = ((tgt - cur) > step) ? up[7:0] : tgt;
        end else if (cur > tgt) begin
            res = ((cur - tgt) > step) ? (cur - step) : tgt;
        end
        return res;
    endfunction

    assign ds          = i_cfg.default_speed;
    assign half_speed  = {1'b0, ds[7:1]};
    assign third_speed = div3(ds);

    assign ramp_left  = ramp(r_left,  r_tgt, i_cfg.ramp_step);
    assign ramp_right = ramp(r_right, r_tgt, i_cfg.ramp_step);

    assign trim_mag = i_cfg.trim_offset[6] ? 6'(-i_cfg.trim_offset) : i_cfg.trim_offset[5:0];

    // Slow one side by the trim, floored at zero
    always_comb begin
        trim_left  = ramp_left;
        trim_right = ramp_right;
        if (i_cfg.trim_offset[6]) begin
            trim_left = (ramp_left >= {2'd0, trim_mag}) ? (ramp_left - {2'd0, trim_mag}) : 8'd0;
        end else begin
            trim_right = (ramp_right >= {2'd0, trim_mag}) ?
                         (ramp_right - {2'd0, trim_mag}) : 8'd0;
        end
    end

    always_comb begin
        n_dir        = r_dir;
        n_tgt        = r_tgt;
        n_left       = r_left;
        n_right      = r_right;
        o_has_result = 1'b0;
        o_result     = '0;
        case (i_kind)
            KIND_TICK: begin
                n_left       = ramp_left;
                n_right      = ramp_right;
                o_has_result = 1'b1;
                if (r_dir == DIR_FWD) begin
                    o_result.left_forward  = duty_limit(trim_left);
                    o_result.right_forward = duty_limit(trim_right);
                end else if (r_dir == DIR_REV) begin
                    o_result.left_reverse  = duty_limit(trim_left);
                    o_result.right_reverse = duty_limit(trim_right);
                end
            end
            KIND_FWD: begin
                n_dir = DIR_FWD;
                n_tgt = ds;
            end
            KIND_BACK: begin
                n_dir = DIR_REV;
                n_tgt = ds;
            end
            KIND_STOP: begin
                n_dir = DIR_STOP;
                n_tgt = 8'd0;
            end
            KIND_ESTOP: begin
                n_dir        = DIR_STOP;
                n_tgt        = 8'd0;
                n_left       = 8'd0;
                n_right      = 8'd0;
                o_has_result = 1'b1;
            end
            KIND_TURN_L: begin
                o_has_result           = 1'b1;
                o_result.left_reverse  = duty_limit(half_speed);
                o_result.right_forward = duty_limit(half_speed);
            end
            KIND_TURN_R: begin
                o_has_result           = 1'b1;
                o_result.left_forward  = duty_limit(half_speed);
                o_result.right_reverse = duty_limit(half_speed);
            end
            KIND_CURVE_L: begin
                o_has_result           = 1'b1;
                o_result.left_forward  = duty_limit(third_speed);
                o_result.right_forward = duty_limit(ds);
            end
            KIND_CURVE_R: begin
                o_has_result           = 1'b1;
                o_result.left_forward  = duty_limit(ds);
                o_result.right_forward = duty_limit(third_speed);
            end
            KIND_SET_SPEED: begin
                n_tgt = i_speed_value;
                // start forward only from a stopped state
                if (r_dir != DIR_FWD && r_dir != DIR_REV && i_speed_value != 8'd0) begin
                    n_dir = DIR_FWD;
                end
            end
            KIND_SET_SMOOTH: begin
                n_tgt = i_speed_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_STOP;
            r_tgt   <= 8'd0;
            r_left  <= 8'd0;
            r_right <= 8'd0;
        end else if (i_fire) begin
            r_dir   <= n_dir;
            r_tgt   <= n_tgt;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

// ----- hdl/ddrc_out_buf.sv -----
// Two-entry result buffer (output register plus skid slot) on the master side.
// Depends on ddrc_pkg.
`timescale 1ns / 1ps

module ddrc_out_buf
    import ddrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_duty i_data,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_duty o_data
);

    logic [1:0] r_count, n_count;
    t_duty      r_head, r_tail;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Payload: head drains from tail, new word lands in the first free slot
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_head <= r_tail;
        end
        if (i_push) begin
            if (i_pop) begin
                if (r_count == 2'd2) begin
                    r_tail <= i_data;
                end else begin
                    r_head <= i_data;
                end
            end else if (r_count == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for differential_drive_ramp_controller: streams commands and ticks,
// predicts the four PWM duties per result and compares them word by word. Needs ddrc_pkg.

module tb;
    import ddrc_pkg::*;

    localparam int         HOLD_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         NUM_SETTINGS  = 8;
    localparam int         WORDS_PER_SET = 66;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] speed;
    } t_cmd;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;   // [7:0] speed_value
    logic [3:0]  i_s_tuser   = '0;   // [3:0] kind
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;          // [7:0] left fwd, [15:8] left rev,
                                     // [23:16] right fwd, [31:24] right rev
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = '0;
    logic [7:0]  i_cfg_wdata = '0;

    differential_drive_ramp_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Drive model state and its copy of the registers
    logic [1:0] run_dir    = DIR_STOP;
    int         target_lvl = 0;
    int         left_lvl   = 0;
    int         right_lvl  = 0;
    int         cfg_speed  = int'(DEFAULT_SPEED_RST);
    int         cfg_step   = int'(RAMP_STEP_RST);
    int         cfg_trim   = 0;

    t_cmd  cmd_q[$];
    t_duty duty_q[$];
    t_cmd  word_s;
    int    gap_s       = 0;
    int    stall_m     = 0;
    bit    s_gaps      = 1'b1;
    bit    m_gaps      = 1'b1;
    int    n_errors    = 0;
    int    n_sent      = 0;
    int    n_results   = 0;
    int    n_settings  = 1;
    int    idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 40)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // {reverse, forward} duty pair for one signed motor speed
    function automatic logic [15:0] pwm_pair(input int speed);
        int         mag;
        logic [7:0] duty;
        mag = (speed < 0) ? -speed : speed;
        if (mag > int'(DUTY_MAX))
            mag = int'(DUTY_MAX);
        duty = mag[7:0];
        if (speed > 0)
            return {8'd0, duty};
        else if (speed < 0)
            return {duty, 8'd0};
        return 16'd0;
    endfunction

    function automatic t_duty motor_duties(input int l, input int r);
        t_duty      d;
        logic [15:0] pl, pr;
        pl = pwm_pair(l);
        pr = pwm_pair(r);
        d.left_forward  = pl[7:0];
        d.left_reverse  = pl[15:8];
        d.right_forward = pr[7:0];
        d.right_reverse = pr[15:8];
        return d;
    endfunction

    function automatic int ramp_toward(input int cur, input int tgt, input int step);
        if (cur < tgt) begin
            cur += step;
            if (cur > tgt)
                cur = tgt;
        end else if (cur > tgt) begin
            cur -= step;
            if (cur < tgt)
                cur = tgt;
        end
        return cur;
    endfunction

    // Advance the drive state for one accepted word and queue its duties, if any
    task automatic predict_duties(input t_cmd c);
        int l, r, ds, half;
        ds   = cfg_speed;
        half = ds / 2;
        case (c.kind)
            KIND_TICK: begin
                left_lvl  = ramp_toward(left_lvl, target_lvl, cfg_step);
                right_lvl = ramp_toward(right_lvl, target_lvl, cfg_step);
                l = left_lvl;
                r = right_lvl;
                if (cfg_trim > 0)
                    r -= cfg_trim;
                else if (cfg_trim < 0)
                    l += cfg_trim;
                if (l < 0) l = 0;
                if (r < 0) r = 0;
                if (run_dir == DIR_FWD)
                    duty_q.push_back(motor_duties(l, r));
                else if (run_dir == DIR_REV)
                    duty_q.push_back(motor_duties(-l, -r));
                else
                    duty_q.push_back(motor_duties(0, 0));
            end
            KIND_FWD: begin
                run_dir    = DIR_FWD;
                target_lvl = ds;
            end
            KIND_BACK: begin
                run_dir    = DIR_REV;
                target_lvl = ds;
            end
            KIND_STOP: begin
                run_dir    = DIR_STOP;
                target_lvl = 0;
            end
            KIND_ESTOP: begin
                run_dir    = DIR_STOP;
                target_lvl = 0;
                left_lvl   = 0;
                right_lvl  = 0;
                duty_q.push_back(motor_duties(0, 0));
            end
            KIND_TURN_L:  duty_q.push_back(motor_duties(-half, half));
            KIND_TURN_R:  duty_q.push_back(motor_duties(half, -half));
            KIND_CURVE_L: duty_q.push_back(motor_duties(ds / 3, ds));
            KIND_CURVE_R: duty_q.push_back(motor_duties(ds, ds / 3));
            KIND_SET_SPEED: begin
                target_lvl = int'(c.speed);
                if (run_dir != DIR_FWD && run_dir != DIR_REV && c.speed != 8'd0)
                    run_dir = DIR_FWD;
            end
            KIND_SET_SMOOTH: target_lvl = int'(c.speed);
            default: ;
        endcase
    endtask

    // Source side: hold each word until taken, then idle for its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_s      <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                predict_duties(word_s);
                n_sent++;
            end
            if (gap_s != 0) begin
                gap_s      <= gap_s - 1;
                i_s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                word_s      = cmd_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= word_s.kind;
                i_s_tdata  <= word_s.speed;
                gap_s      <= draw_gap(s_gaps);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each word against the oldest prediction, then stall at random
    t_duty got_d, want_d;
    int    stall_draw;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_m    <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            n_results++;
            got_d = o_m_tdata;
            if (duty_q.size() == 0) begin
                report_mismatch("result with nothing expected", o_m_tdata, 0);
            end else begin
                want_d = duty_q.pop_front();
                if (got_d.left_forward !== want_d.left_forward)
                    report_mismatch("left forward duty", int'(got_d.left_forward),
                                    int'(want_d.left_forward));
                if (got_d.left_reverse !== want_d.left_reverse)
                    report_mismatch("left reverse duty", int'(got_d.left_reverse),
                                    int'(want_d.left_reverse));
                if (got_d.right_forward !== want_d.right_forward)
                    report_mismatch("right forward duty", int'(got_d.right_forward),
                                    int'(want_d.right_forward));
                if (got_d.right_reverse !== want_d.right_reverse)
                    report_mismatch("right reverse duty", int'(got_d.right_reverse),
                                    int'(want_d.right_reverse));
            end
            stall_draw  = draw_gap(m_gaps);
            stall_m    <= stall_draw;
            i_m_tready <= (stall_draw == 0);
        end else if (stall_m != 0) begin
            stall_m    <= stall_m - 1;
            i_m_tready <= (stall_m == 1);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= HOLD_LIMIT);
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 HOLD_LIMIT, duty_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic push_cmd(input logic [3:0] kind, input logic [7:0] speed);
        t_cmd c;
        c.kind  = kind;
        c.speed = speed;
        cmd_q.push_back(c);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        logic signed [6:0] raw;
        int                v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            REG_DEFAULT_SPEED: cfg_speed = int'(data);
            REG_RAMP_STEP:     cfg_step  = int'(data);
            REG_TRIM_OFFSET: begin
                raw = data[6:0];
                v   = int'(raw);
                if (v > int'(TRIM_MAX)) v = int'(TRIM_MAX);
                if (v < int'(TRIM_MIN)) v = int'(TRIM_MIN);
                cfg_trim = v;
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every queued word to be taken and every result to come back;
    // sample between edges so the source side has settled
    task automatic drain();
        while (cmd_q.size() != 0 || i_s_tvalid || duty_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_speed();
        logic [7:0] edges[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ticks between steering commands so the ramp gets exercised; a few
    // unused kinds mixed in as noise
    function automatic logic [3:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return KIND_TICK;
        if (r < 58) return KIND_FWD;
        if (r < 64) return KIND_BACK;
        if (r < 69) return KIND_STOP;
        if (r < 77) return KIND_SET_SPEED;
        if (r < 84) return KIND_SET_SMOOTH;
        if (r < 94) return 4'($urandom_range(int'(KIND_ESTOP), int'(KIND_CURVE_R)));
        return 4'($urandom_range(11, 15));
    endfunction

    initial begin
        logic [7:0] set_speed, set_step, set_trim;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stopped tick, ramp up, turns and curves, reverse, stops,
        // set speed from standstill, zero targets, unused kinds
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_FWD, 8'd0);
        repeat (3) push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_TURN_L, 8'd0);
        push_cmd(KIND_TURN_R, 8'd0);
        push_cmd(KIND_CURVE_L, 8'd0);
        push_cmd(KIND_CURVE_R, 8'd0);
        push_cmd(KIND_BACK, 8'd0);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_SET_SMOOTH, 8'd255);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_STOP, 8'd0);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_ESTOP, 8'd0);
        push_cmd(KIND_SET_SPEED, 8'd0);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_SET_SPEED, 8'd255);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(4'd11, 8'hFF);
        push_cmd(4'd15, 8'h00);
        push_cmd(KIND_SET_SMOOTH, 8'd0);
        push_cmd(KIND_TICK, 8'd0);
        push_cmd(KIND_ESTOP, 8'd0);
        drain();

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: begin set_speed = 8'd255; set_step = 8'd255; set_trim = 8'h32; end
                1: begin set_speed = 8'd0;   set_step = 8'd1;   set_trim = 8'h4E; end
                2: begin set_speed = 8'd255; set_step = 8'd0;   set_trim = 8'h3F; end
                3: begin set_speed = 8'd1;   set_step = 8'd1;   set_trim = 8'hC0; end
                default: begin
                    set_speed = 8'($urandom_range(0, 255));
                    set_step  = 8'($urandom_range(1, 40));
                    set_trim  = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_DEFAULT_SPEED, set_speed);
            write_reg(REG_RAMP_STEP, set_step);
            write_reg(REG_TRIM_OFFSET, set_trim);
            if (ph == 0)
                write_reg(REG_SPARE, 8'hA5);
            n_settings++;
            s_gaps = (ph % 4 == 0 || ph % 4 == 1);
            m_gaps = (ph % 4 == 0 || ph % 4 == 2);
            for (int k = 0; k < WORDS_PER_SET; k++)
                push_cmd(pick_kind(), pick_speed());
            drain();
        end

        if (duty_q.size() != 0)
            report_mismatch("results never produced", duty_q.size(), 0);
        $display("%0d command and tick words sent, %0d duty words checked", n_sent, n_results);
        $display("%0d register settings, sender and receiver gaps on and off", n_settings);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
